### sv/spnm_pkg.sv
// Package for the shaded nearest palette match block.
// Holds widths, reset values, register indexes and sequencer codes.
// No dependencies.
package spnm_pkg;

    // Palette store size and its address width
    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);

    // Field widths
    localparam int CHAN_W  = 8;
    localparam int INDEX_W = 8;
    localparam int SHADE_W = 8;
    localparam int CNT_W   = 9;
    localparam int CFG_W   = 9;

    // Window arithmetic: base plus range never exceeds this width
    localparam int WIN_W = 10;

    // Lighting arithmetic
    localparam int MUL_A_W = 10;
    localparam int NUM_W   = 18;
    localparam int DEN_W   = 11;
    localparam int LIT_W   = NUM_W;
    localparam int DCNT_W  = $clog2(NUM_W);
    localparam int SQ_W    = 2 * LIT_W;
    localparam int DIST_W  = SQ_W + 2;

    // Reset values and fixed codes
    localparam logic [CNT_W-1:0]   SHADE_COUNT_RESET = 9'd64;
    localparam logic [INDEX_W-1:0] DEST_BASE_RESET   = 8'd0;
    localparam logic [CNT_W-1:0]   DEST_RANGE_RESET  = 9'd256;
    localparam logic [INDEX_W-1:0] NO_MATCH_INDEX    = 8'd127;
    localparam logic [CHAN_W-1:0]  CHAN_FULL         = 8'd255;

    // Command codes
    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0]
    {
        REG_SHADE_COUNT = 2'd0,
        REG_DEST_BASE   = 2'd1,
        REG_DEST_RANGE  = 2'd2
    } cfg_reg_t;

    // Color channel being lit
    typedef enum logic [1:0]
    {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    // Sequencer states
    typedef enum logic [6:0]
    {
        ST_IDLE   = 7'b0000001,
        ST_MUL_A  = 7'b0000010,
        ST_MUL_B  = 7'b0000100,
        ST_DIVIDE = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

endpackage

### sv/shade_palette_nearest_match.sv
// Top level of the shaded nearest palette match block.
// Holds the palette memory, the lighting sequencer with its shared multiply and
// divide unit, and the pipelined window scan. Depends on spnm_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): a load request (command 0) writes red,
//   green and blue into palette entry entry_index in the accept cycle and
//   gives no result; the block is ready again in the next cycle. A query
//   request (command 1) lights the source color to shade_level and returns
//   the index of the closest entry in the window on the output channel
//   (out_valid/out_ready), with match_found low and index 127 for an empty
//   window.
//   Config channel (cfg_valid/cfg_ready): always ready; write shade_count,
//   dest_base and dest_range only while no query is in flight.
//   A query runs three channels, each through the multiply states MUL_A and
//   MUL_B and an 18-step restoring divide on the shared unit, then one palette
//   read per cycle over the clipped window and a three-stage distance
//   pipeline. in_ready is low meanwhile, so the block takes no new request
//   until the query is through.
//   Reset clears the sequencer and loads the register reset values; palette
//   entries hold garbage until written.
//   A stalled receiver holds the result in the output register; the block
//   takes the next request meanwhile and waits only when a new result is
//   ready and the output register is still full.
module shade_palette_nearest_match
    import spnm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input request channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [INDEX_W-1:0]   entry_index,
    input  logic [CHAN_W-1:0]    red,
    input  logic [CHAN_W-1:0]    green,
    input  logic [CHAN_W-1:0]    blue,
    input  logic [SHADE_W-1:0]   shade_level,
    // Result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [INDEX_W-1:0]   nearest_index,
    output logic                 match_found,
    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers
    logic [CNT_W-1:0]    shade_count_reg;
    logic [INDEX_W-1:0]  dest_base_reg;
    logic [CNT_W-1:0]    dest_range_reg;

    // Sequencer
    state_t              state_reg, state_next;
    chan_t               chan_reg;
    logic [DCNT_W-1:0]   div_cnt_reg;

    // Captured query
    logic [CHAN_W-1:0]   red_reg, green_reg, blue_reg;
    logic [SHADE_W-1:0]  shade_reg;

    // Shared lighting unit
    logic [NUM_W-1:0]    acc_reg;
    logic [DEN_W-1:0]    div_rem_reg;
    logic [NUM_W-1:0]    div_quo_reg;
    logic [LIT_W-1:0]    lit_r_reg, lit_g_reg, lit_b_reg;

    // Scan pipeline
    logic [WIN_W-1:0]    scan_n_reg;
    logic [WIN_W-1:0]    win_end;
    logic [23:0]         palette_mem [PALETTE_ENTRIES];
    logic [23:0]         rd_data_reg;
    logic                rd_vld_reg, sq_vld_reg, sum_vld_reg;
    logic [INDEX_W-1:0]  rd_idx_reg, sq_idx_reg, sum_idx_reg;
    logic [SQ_W-1:0]     sq_r_reg, sq_g_reg, sq_b_reg;
    logic [DIST_W-1:0]   sum_reg;
    logic [DIST_W-1:0]   best_d_reg;
    logic [INDEX_W-1:0]  best_i_reg;
    logic                found_reg;

    // Output register
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_found_reg;

    // Lighting operands
    logic [CNT_W-1:0]    shades_t;
    logic [DEN_W-1:0]    three_t;
    logic [DEN_W-1:0]    four_s;
    logic                dim_case;
    logic [DEN_W-1:0]    over_u;
    logic [DEN_W-1:0]    divisor;
    logic [CHAN_W-1:0]   cur_chan;
    logic [MUL_A_W-1:0]  mul_a;
    logic [CHAN_W-1:0]   mul_b;
    logic [NUM_W-1:0]    product;
    logic [NUM_W:0]      acc_sum;
    logic [DEN_W:0]      div_trial;
    logic                div_take;
    logic [DEN_W:0]      div_diff;
    logic [NUM_W-1:0]    quo_next;
    logic [LIT_W-1:0]    d_r, d_g, d_b;

    logic                in_acc;
    logic                scan_issue;
    logic                out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign nearest_index = out_index_reg;
    assign match_found   = out_found_reg;

    // Take configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shade_count_reg <= SHADE_COUNT_RESET;
            dest_base_reg   <= DEST_BASE_RESET;
            dest_range_reg  <= DEST_RANGE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SHADE_COUNT: shade_count_reg <= cfg_data;
                REG_DEST_BASE:   dest_base_reg   <= cfg_data[INDEX_W-1:0];
                REG_DEST_RANGE:  dest_range_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Lighting operands: zero shade count acts as one
    always_comb
    begin
        shades_t = (shade_count_reg == '0) ? CNT_W'(1) : shade_count_reg;
        three_t  = DEN_W'(shades_t) + {1'b0, shades_t, 1'b0};
        four_s   = {1'b0, shade_reg, 2'b00};
        dim_case = four_s < three_t;
        over_u   = four_s - three_t;
        divisor  = dim_case ? three_t : DEN_W'(shades_t);

        case (chan_reg)
            CH_RED:   cur_chan = red_reg;
            CH_GREEN: cur_chan = green_reg;
            CH_BLUE:  cur_chan = blue_reg;
            default:  cur_chan = red_reg;
        endcase

        // Dim: 4s*c. Bright: T*c + (4s-3T)*(255-c)
        if (state_reg == ST_MUL_A)
        begin
            mul_a = dim_case ? four_s[MUL_A_W-1:0] : MUL_A_W'(shades_t);
            mul_b = cur_chan;
        end
        else
        begin
            mul_a = dim_case ? '0 : over_u[MUL_A_W-1:0];
            mul_b = CHAN_FULL - cur_chan;
        end
        product = NUM_W'(mul_a) * NUM_W'(mul_b);
        acc_sum = {1'b0, acc_reg} + {1'b0, product};
    end

    // One restoring divide step
    always_comb
    begin
        div_trial = {div_rem_reg, div_quo_reg[NUM_W-1]};
        div_take  = div_trial >= {1'b0, divisor};
        div_diff  = div_trial - {1'b0, divisor};
        quo_next  = {div_quo_reg[NUM_W-2:0], div_take};
    end

    // Clip the search window at the store end
    always_comb
    begin
        win_end = WIN_W'(dest_base_reg) + WIN_W'(dest_range_reg);
        if (win_end > WIN_W'(PALETTE_ENTRIES))
        begin
            win_end = WIN_W'(PALETTE_ENTRIES);
        end
    end

    assign scan_issue = (state_reg == ST_SCAN) && (scan_n_reg < win_end);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (command == CMD_QUERY))
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:  state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_cnt_reg == DCNT_W'(NUM_W - 1))
                begin
                    state_next = (chan_reg == CH_BLUE) ? ST_SCAN : ST_MUL_A;
                end
            end
            ST_SCAN:
            begin
                if (!scan_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !sq_vld_reg && !sum_vld_reg)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= CH_RED;
            div_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            sq_vld_reg    <= 1'b0;
            sum_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= scan_issue;
            sq_vld_reg  <= rd_vld_reg;
            sum_vld_reg <= sq_vld_reg;

            // Advance channel and divide step count
            if (state_reg == ST_IDLE)
            begin
                chan_reg <= CH_RED;
            end
            if (state_reg == ST_MUL_B)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == ST_DIVIDE)
            begin
                div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(NUM_W - 1))
                begin
                    case (chan_reg)
                        CH_RED:   chan_reg <= CH_GREEN;
                        CH_GREEN: chan_reg <= CH_BLUE;
                        default:  chan_reg <= CH_RED;
                    endcase
                end
            end

            // Track whether any entry was compared
            if (state_reg == ST_IDLE)
            begin
                found_reg <= 1'b0;
            end
            else if (sum_vld_reg)
            begin
                found_reg <= 1'b1;
            end

            // Hold the result until taken
            if (state_reg == ST_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Palette memory: write on load, registered read during the scan
    always_ff @(posedge clk)
    begin
        if (in_acc && (command == CMD_LOAD)
            && ({1'b0, entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES)))
        begin
            palette_mem[entry_index[IDX_W-1:0]] <= {red, green, blue};
        end
        if (scan_issue)
        begin
            rd_data_reg <= palette_mem[scan_n_reg[IDX_W-1:0]];
        end
    end

    // Channel differences against the lit color
    always_comb
    begin
        d_r = (lit_r_reg > LIT_W'(rd_data_reg[23:16]))
            ? lit_r_reg - LIT_W'(rd_data_reg[23:16])
            : LIT_W'(rd_data_reg[23:16]) - lit_r_reg;
        d_g = (lit_g_reg > LIT_W'(rd_data_reg[15:8]))
            ? lit_g_reg - LIT_W'(rd_data_reg[15:8])
            : LIT_W'(rd_data_reg[15:8]) - lit_g_reg;
        d_b = (lit_b_reg > LIT_W'(rd_data_reg[7:0]))
            ? lit_b_reg - LIT_W'(rd_data_reg[7:0])
            : LIT_W'(rd_data_reg[7:0]) - lit_b_reg;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        // Capture the query
        if (in_acc)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            shade_reg <= shade_level;
        end

        // Build the numerator in states MUL_A and MUL_B
        if (state_reg == ST_MUL_A)
        begin
            acc_reg <= product;
        end
        if (state_reg == ST_MUL_B)
        begin
            div_quo_reg <= acc_sum[NUM_W-1:0];
            div_rem_reg <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            div_quo_reg <= quo_next;
            div_rem_reg <= div_take ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
            if (div_cnt_reg == DCNT_W'(NUM_W - 1))
            begin
                case (chan_reg)
                    CH_RED:   lit_r_reg <= quo_next;
                    CH_GREEN: lit_g_reg <= quo_next;
                    default:  lit_b_reg <= quo_next;
                endcase
            end
        end

        // Start the scan at the window base
        if (state_reg == ST_IDLE)
        begin
            scan_n_reg <= WIN_W'(dest_base_reg);
            best_i_reg <= NO_MATCH_INDEX;
        end
        else if (scan_issue)
        begin
            scan_n_reg <= scan_n_reg + WIN_W'(1);
        end

        // Scan pipeline: read, square, sum, compare
        rd_idx_reg  <= scan_n_reg[INDEX_W-1:0];
        sq_idx_reg  <= rd_idx_reg;
        sum_idx_reg <= sq_idx_reg;
        sq_r_reg    <= SQ_W'(d_r) * SQ_W'(d_r);
        sq_g_reg    <= SQ_W'(d_g) * SQ_W'(d_g);
        sq_b_reg    <= SQ_W'(d_b) * SQ_W'(d_b);
        sum_reg     <= DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

        // Keep the first least distance
        if (sum_vld_reg && (!found_reg || (sum_reg < best_d_reg)))
        begin
            best_d_reg <= sum_reg;
            best_i_reg <= sum_idx_reg;
        end

        // Load the output register
        if (state_reg == ST_RESULT && out_free)
        begin
            out_index_reg <= best_i_reg;
            out_found_reg <= found_reg;
        end
    end

endmodule
